FILE: hw/rtl/baro_sensor_compensation_assert.svh
`ifndef BARO_SENSOR_COMPENSATION_ASSERT_SVH
`define BARO_SENSOR_COMPENSATION_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define BARO_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("baro compensation assertion failed");

// check that cons follows ante after the delay given by dly
`define BARO_ASSERT_DELAY(label, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error("baro compensation latency assertion failed");

`endif

FILE: hw/rtl/baro_pkg.sv
package baro_pkg;

  // configuration port
  localparam int ADDR_W = 5;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_PRES_SENS  = 3'd0,
    REG_PRES_OFF   = 3'd1,
    REG_SENS_TC    = 3'd2,
    REG_OFF_TC     = 3'd3,
    REG_REF_TEMP   = 3'd4,
    REG_TEMP_COEFF = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] pressure_sensitivity;
    logic [15:0] pressure_offset;
    logic [15:0] sensitivity_temp_coeff;
    logic [15:0] offset_temp_coeff;
    logic [15:0] reference_temperature;
    logic [15:0] temperature_coeff;
  } calib_t;

  // compensation constants
  localparam int TEMP_REF       = 2000;
  localparam int TEMP_LOW       = -1500;
  localparam int OFF2_GAIN      = 61;
  localparam int OFF2_LOW_GAIN  = 15;
  localparam int SENS2_GAIN     = 2;
  localparam int SENS2_LOW_GAIN = 8;

  // output ranges
  localparam int TEMP_MIN = -4000;
  localparam int TEMP_MAX = 8500;
  localparam int PRES_MIN = 1000;
  localparam int PRES_MAX = 120000;

  // pipeline depth from accept to done
  localparam int STAGES = 11;

endpackage

FILE: hw/rtl/baro_sensor_compensation.sv
// Barometric sensor compensation. One raw pressure / raw temperature pair is
// taken at each clock edge where start is high and busy is low; busy never
// rises, so a new pair may be started in every cycle. Each pair yields one
// result (temperature in hundredths of a degree, pressure in pascal, clamp
// flag) that appears on the result ports for exactly one cycle with done high,
// in start order. The receiver cannot hold results off, and nothing inside ever
// stalls. The rate of one pair per cycle is set by the eleven-stage datapath,
// whose longest piece is the signed 24 by 40 bit pressure product, split into
// two partial products in one stage and summed in the next. Calibration words
// are written through the APB-style port at byte address 4*i and may only
// change while no transfer is in flight.

`include "baro_sensor_compensation_assert.svh"

module baro_sensor_compensation (
  input  logic                          clk,
  input  logic                          rst,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [23:0]                   raw_pressure,
  input  logic [23:0]                   raw_temperature,
  // result side
  output logic                          done,
  output logic signed [14:0]            temperature_centi,
  output logic [16:0]                   pressure_pascal,
  output logic                          clamped,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [baro_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import baro_pkg::*;

  localparam int LATENCY = STAGES;

  // ---------------------------------------------------------------------------
  // calibration registers
  // ---------------------------------------------------------------------------
  calib_t               cal;
  logic                 wr_en;
  logic [IDX_W-1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PRES_SENS:  cal.pressure_sensitivity   <= pwdata[15:0];
        REG_PRES_OFF:   cal.pressure_offset        <= pwdata[15:0];
        REG_SENS_TC:    cal.sensitivity_temp_coeff <= pwdata[15:0];
        REG_OFF_TC:     cal.offset_temp_coeff      <= pwdata[15:0];
        REG_REF_TEMP:   cal.reference_temperature  <= pwdata[15:0];
        REG_TEMP_COEFF: cal.temperature_coeff      <= pwdata[15:0];
        default: ;  // addresses past the last word are ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PRES_SENS:  prdata = {16'd0, cal.pressure_sensitivity};
      REG_PRES_OFF:   prdata = {16'd0, cal.pressure_offset};
      REG_SENS_TC:    prdata = {16'd0, cal.sensitivity_temp_coeff};
      REG_OFF_TC:     prdata = {16'd0, cal.offset_temp_coeff};
      REG_REF_TEMP:   prdata = {16'd0, cal.reference_temperature};
      REG_TEMP_COEFF: prdata = {16'd0, cal.temperature_coeff};
      default:        prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake and valid chain
  // ---------------------------------------------------------------------------
  logic                 accept;
  logic [STAGES-1:0]    vld;

  // the pipeline takes a pair in every cycle and never backs up
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[STAGES-2:0], accept};
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers (no reset, meaning carried by vld)
  // ---------------------------------------------------------------------------
  // stage 1: temperature difference
  logic signed [24:0]   dt_s1;
  logic [23:0]          d1_s1;
  // stage 2: first-order products
  logic signed [41:0]   pt_s2;      // dt * c6
  logic signed [41:0]   po_s2;      // c4 * dt
  logic signed [41:0]   ps_s2;      // c3 * dt
  logic signed [49:0]   pdd_s2;     // dt * dt
  logic [23:0]          d1_s2;
  // stage 3: first-order temperature, offset, sensitivity
  logic signed [18:0]   temp_s3;
  logic signed [35:0]   off_s3;
  logic signed [34:0]   sens_s3;
  logic [16:0]          t2_s3;
  logic [23:0]          d1_s3;
  // stage 4: low temperature squares
  logic [33:0]          aa_s4;
  logic [33:0]          bb_s4;
  logic signed [19:0]   temp_s4;
  logic signed [35:0]   off_s4;
  logic signed [34:0]   sens_s4;
  logic [23:0]          d1_s4;
  // stage 5: second-order offset and sensitivity terms
  logic [38:0]          off2_s5;
  logic [37:0]          sens2_s5;
  logic signed [19:0]   temp_s5;
  logic signed [35:0]   off_s5;
  logic signed [34:0]   sens_s5;
  logic [23:0]          d1_s5;
  // stage 6: corrected offset and sensitivity, clamped temperature
  logic signed [40:0]   off_f_s6;
  logic signed [39:0]   sens_f_s6;
  logic signed [14:0]   tc_s6;
  logic                 thit_s6;
  logic [23:0]          d1_s6;
  // stage 7: pressure partial products
  logic [43:0]          pl_s7;
  logic signed [44:0]   ph_s7;
  logic signed [40:0]   off_f_s7;
  logic signed [14:0]   tc_s7;
  logic                 thit_s7;
  // stage 8: full pressure product
  logic signed [63:0]   prod_s8;
  logic signed [40:0]   off_f_s8;
  logic signed [14:0]   tc_s8;
  logic                 thit_s8;
  // stage 9: product scaled down
  logic signed [42:0]   q1_s9;
  logic signed [40:0]   off_f_s9;
  logic signed [14:0]   tc_s9;
  logic                 thit_s9;
  // stage 10: offset removed
  logic signed [43:0]   diff_s10;
  logic signed [14:0]   tc_s10;
  logic                 thit_s10;

  // ---------------------------------------------------------------------------
  // combinational pieces between stages
  // ---------------------------------------------------------------------------
  // divisions by powers of two round toward zero: add 2^k-1 to negative values
  logic [41:0]          pt_adj;
  logic [41:0]          po_adj;
  logic [41:0]          ps_adj;
  logic signed [18:0]   a_full;
  logic signed [18:0]   b_full;
  logic                 lt_ref;
  logic                 lt_low;
  logic signed [17:0]   a_g;
  logic signed [17:0]   b_g;
  logic signed [35:0]   sq_a;
  logic signed [35:0]   sq_b;
  logic [39:0]          off2_a;
  logic [37:0]          off2_b;
  logic [63:0]          prod_adj;
  logic [43:0]          diff_adj;
  logic signed [28:0]   pq;

  always_comb begin
    pt_adj = pt_s2 + 42'({23{pt_s2[41]}});
    po_adj = po_s2 + 42'({6{po_s2[41]}});
    ps_adj = ps_s2 + 42'({7{ps_s2[41]}});

    // second-order terms only apply below 20 C, the extra ones below -15 C
    a_full = temp_s3 - 19'(TEMP_REF);
    b_full = temp_s3 - 19'(TEMP_LOW);
    lt_ref = temp_s3 < 19'(TEMP_REF);
    lt_low = temp_s3 < 19'(TEMP_LOW);
    a_g    = lt_ref ? a_full[17:0] : 18'sd0;
    b_g    = lt_low ? b_full[17:0] : 18'sd0;
    sq_a   = a_g * a_g;
    sq_b   = b_g * b_g;

    off2_a = 40'(aa_s4) * 40'(OFF2_GAIN);
    off2_b = 38'(bb_s4) * 38'(OFF2_LOW_GAIN);

    prod_adj = prod_s8 + 64'({21{prod_s8[63]}});
    diff_adj = diff_s10 + 44'({15{diff_s10[43]}});
    pq       = $signed(diff_adj[43:15]);
  end

  always_ff @(posedge clk) begin
    // stage 1
    dt_s1 <= $signed({1'b0, raw_temperature})
           - $signed({1'b0, cal.reference_temperature, 8'd0});
    d1_s1 <= raw_pressure;

    // stage 2
    pt_s2  <= dt_s1 * $signed({1'b0, cal.temperature_coeff});
    po_s2  <= dt_s1 * $signed({1'b0, cal.offset_temp_coeff});
    ps_s2  <= dt_s1 * $signed({1'b0, cal.sensitivity_temp_coeff});
    pdd_s2 <= dt_s1 * dt_s1;
    d1_s2  <= d1_s1;

    // stage 3
    temp_s3 <= 19'(TEMP_REF) + $signed(pt_adj[41:23]);
    off_s3  <= 36'($signed({1'b0, cal.pressure_offset, 17'd0}))
             + $signed(po_adj[41:6]);
    sens_s3 <= 35'($signed({1'b0, cal.pressure_sensitivity, 16'd0}))
             + $signed(ps_adj[41:7]);
    t2_s3   <= pdd_s2[47:31];   // dt squared is never negative
    d1_s3   <= d1_s2;

    // stage 4
    aa_s4   <= sq_a[33:0];
    bb_s4   <= sq_b[33:0];
    temp_s4 <= lt_ref ? 20'(temp_s3) - 20'($signed({1'b0, t2_s3})) : 20'(temp_s3);
    off_s4  <= off_s3;
    sens_s4 <= sens_s3;
    d1_s4   <= d1_s3;

    // stage 5
    off2_s5  <= 39'(off2_a[39:4]) + 39'(off2_b);
    sens2_s5 <= 38'(aa_s4) * 38'(SENS2_GAIN) + 38'(bb_s4) * 38'(SENS2_LOW_GAIN);
    temp_s5  <= temp_s4;
    off_s5   <= off_s4;
    sens_s5  <= sens_s4;
    d1_s5    <= d1_s4;

    // stage 6
    off_f_s6  <= 41'(off_s5) - 41'($signed({1'b0, off2_s5}));
    sens_f_s6 <= 40'(sens_s5) - 40'($signed({1'b0, sens2_s5}));
    if (temp_s5 < 20'(TEMP_MIN)) begin
      tc_s6   <= 15'(TEMP_MIN);
      thit_s6 <= 1'b1;
    end else if (temp_s5 > 20'(TEMP_MAX)) begin
      tc_s6   <= 15'(TEMP_MAX);
      thit_s6 <= 1'b1;
    end else begin
      tc_s6   <= temp_s5[14:0];
      thit_s6 <= 1'b0;
    end
    d1_s6 <= d1_s5;

    // stage 7: sensitivity split into a signed high half and unsigned low half
    pl_s7    <= 44'(d1_s6) * 44'(sens_f_s6[19:0]);
    ph_s7    <= $signed({1'b0, d1_s6}) * $signed(sens_f_s6[39:20]);
    off_f_s7 <= off_f_s6;
    tc_s7    <= tc_s6;
    thit_s7  <= thit_s6;

    // stage 8
    prod_s8  <= (64'(ph_s7) <<< 20) + 64'($signed({1'b0, pl_s7}));
    off_f_s8 <= off_f_s7;
    tc_s8    <= tc_s7;
    thit_s8  <= thit_s7;

    // stage 9
    q1_s9    <= $signed(prod_adj[63:21]);
    off_f_s9 <= off_f_s8;
    tc_s9    <= tc_s8;
    thit_s9  <= thit_s8;

    // stage 10
    diff_s10 <= 44'(q1_s9) - 44'(off_f_s9);
    tc_s10   <= tc_s9;
    thit_s10 <= thit_s9;

    // stage 11: pressure clamp and result registers
    temperature_centi <= tc_s10;
    if (pq < 29'(PRES_MIN)) begin
      pressure_pascal <= 17'(PRES_MIN);
      clamped         <= 1'b1;
    end else if (pq > 29'(PRES_MAX)) begin
      pressure_pascal <= 17'(PRES_MAX);
      clamped         <= 1'b1;
    end else begin
      pressure_pascal <= pq[16:0];
      clamped         <= thit_s10;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic                 at_bound;

  // result sits on one of the range bounds
  assign at_bound = (temperature_centi == 15'(TEMP_MIN))
                 || (temperature_centi == 15'(TEMP_MAX))
                 || (pressure_pascal == 17'(PRES_MIN))
                 || (pressure_pascal == 17'(PRES_MAX));

  // every accepted pair comes out with done once it has passed the pipeline
  `BARO_ASSERT_DELAY(a_latency, accept, LATENCY, done)
  // no result without an accepted pair behind it
  `BARO_ASSERT_IMPL(a_origin, done, $past(accept, LATENCY))
  // a clamped result sits on one of the range bounds
  `BARO_ASSERT_IMPL(a_clamp_bound, done && clamped, at_bound)

endmodule
